// ----- rtl/utf8_fullwidth_to_halfwidth_core_assert.svh -----
// Assertion macros shared by the converter RTL.
`ifndef UTF8_FULLWIDTH_TO_HALFWIDTH_CORE_ASSERT_SVH
`define UTF8_FULLWIDTH_TO_HALFWIDTH_CORE_ASSERT_SVH

// Check that a condition holds on every clock edge out of reset.
`define UFW_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define UFW_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define UFW_ASSERT_SAME(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/utf8fw_pkg.sv -----
package utf8fw_pkg;

   // Bytes produced by one request, in output order
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic       done;
   } conv_result_type;

   // One queued output byte with its flags
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } out_entry_type;

   localparam int unsigned MAX_RESULTS = 3;

endpackage

// ----- rtl/utf8fw_conv.sv -----
`include "utf8_fullwidth_to_halfwidth_core_assert.svh"

module utf8fw_conv
   import utf8fw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_byte,
   input  logic            end_of_stream,
   output conv_result_type result
);

   localparam logic [7:0] LEAD_BYTE  = 8'hEF;
   localparam logic [7:0] SECOND_LOW = 8'hBD;
   localparam logic [7:0] SECOND_UP  = 8'hBC;

   localparam logic [1:0] HOLD_NONE   = 2'd0;
   localparam logic [1:0] HOLD_LEAD   = 2'd1;
   localparam logic [1:0] HOLD_SECOND = 2'd2;

   logic [1:0] held_count_ff;
   logic [1:0] held_count_in;
   logic [7:0] held_second_ff;
   logic [7:0] held_second_in;
   logic       copy_next_raw_ff;
   logic       copy_next_raw_in;
   logic [7:0] mapped;

   // Third byte after EF BD
   function automatic logic [7:0] map_low(input logic [7:0] x);
      logic [7:0] y;
      y = x;
      if (x >= 8'h41 && x <= 8'h5A) begin
         y = x + 8'h20;
      end else if (x >= 8'h81 && x <= 8'h9A) begin
         y = x - 8'h20;
      end
      return y;
   endfunction

   // Third byte after EF BC
   function automatic logic [7:0] map_up(input logic [7:0] x);
      logic [7:0] y;
      y = x;
      if (x >= 8'h41 && x <= 8'h5A) begin
         y = x + 8'h20;
      end else if ((x >= 8'h90 && x <= 8'h99) || (x >= 8'hA1 && x <= 8'hBB)) begin
         y = x - 8'h60;
      end
      return y;
   endfunction

   assign mapped = (held_second_ff == SECOND_LOW) ? map_low(in_byte) : map_up(in_byte);

   // Decide the emitted bytes and the next hold state
   always_comb begin
      result           = '0;
      result.done      = end_of_stream;
      held_count_in    = HOLD_NONE;
      held_second_in   = held_second_ff;
      copy_next_raw_in = 1'b0;

      priority if (copy_next_raw_ff) begin
         result.count = 2'd1;
         result.data0 = in_byte;
      end else if (held_count_ff == HOLD_LEAD) begin
         if (in_byte == SECOND_LOW || in_byte == SECOND_UP) begin
            held_second_in = in_byte;
            held_count_in  = HOLD_SECOND;
         end else begin
            result.count     = 2'd2;
            result.data0     = LEAD_BYTE;
            result.data1     = in_byte;
            copy_next_raw_in = 1'b1;
         end
      end else if (held_count_ff == HOLD_SECOND) begin
         if (mapped != in_byte) begin
            result.count = 2'd1;
            result.data0 = mapped;
         end else begin
            result.count = 2'd3;
            result.data0 = LEAD_BYTE;
            result.data1 = held_second_ff;
            result.data2 = in_byte;
         end
      end else begin
         if (in_byte == LEAD_BYTE) begin
            held_count_in = HOLD_LEAD;
         end else begin
            result.count = 2'd1;
            result.data0 = in_byte;
         end
      end

      // Flush held bytes raw at end of stream; nothing was emitted in that case
      if (end_of_stream) begin
         if (held_count_in == HOLD_LEAD) begin
            result.count = 2'd1;
            result.data0 = LEAD_BYTE;
         end else if (held_count_in == HOLD_SECOND) begin
            result.count = 2'd2;
            result.data0 = LEAD_BYTE;
            result.data1 = held_second_in;
         end
         held_count_in    = HOLD_NONE;
         held_second_in   = '0;
         copy_next_raw_in = 1'b0;
      end
   end

   // Advance the hold state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff    <= HOLD_NONE;
         held_second_ff   <= '0;
         copy_next_raw_ff <= 1'b0;
      end else if (accept) begin
         held_count_ff    <= held_count_in;
         held_second_ff   <= held_second_in;
         copy_next_raw_ff <= copy_next_raw_in;
      end
   end

   `UFW_ASSERT_ALWAYS(a_hold_in_range, held_count_ff != 2'd3, "hold count reached 3")
   `UFW_ASSERT_SAME(a_raw_copy_no_hold, copy_next_raw_ff, held_count_ff == HOLD_NONE,
                    "raw copy pending while bytes held")
   `UFW_ASSERT_NEXT(a_eos_clears, accept && end_of_stream,
                    held_count_ff == HOLD_NONE && !copy_next_raw_ff,
                    "state not cleared after end of stream")

endmodule

// ----- rtl/utf8_fullwidth_to_halfwidth_core.sv -----
// UTF-8 fullwidth-to-halfwidth converter.
// Requests carry one source byte (req_in_byte) and an end-of-stream flag
// (req_end_of_stream) over a valid/ready handshake. Each request yields zero
// to three response bytes on rsp_out_byte; rsp_last_of_run marks the final
// byte caused by a request and rsp_stream_done the final byte of the stream.
// Fullwidth letters and digits (EF BD x, EF BC x) come out as one ASCII byte;
// held lead bytes are flushed raw at end of stream.
// Response bytes are registered in the output queue before they are presented.
// Throughput: one request and one response byte per cycle while the receiver
// is ready; a request that produces two or three bytes holds off the next
// request while the four-entry output queue drains.
// req_ready is high while at most one byte is queued, so it depends only on
// registered state, never on rsp_ready. When the receiver stalls the queue
// fills and req_ready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue and clears the hold state.
`include "utf8_fullwidth_to_halfwidth_core_assert.svh"

module utf8_fullwidth_to_halfwidth_core
   import utf8fw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_stream_done
);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   conv_result_type         conv_res;
   out_entry_type           queue_ff [QUEUE_DEPTH];
   out_entry_type           wr_entry [MAX_RESULTS];
   logic [PTR_W-1:0]        wr_idx   [MAX_RESULTS];
   logic [PTR_W-1:0]        head_ff;
   logic [PTR_W-1:0]        head_in;
   logic [PTR_W-1:0]        tail_ff;
   logic [PTR_W-1:0]        tail_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    push;
   logic                    pop;

   utf8fw_conv u_conv (
      .clock         (clock),
      .reset         (reset),
      .accept        (push),
      .in_byte       (req_in_byte),
      .end_of_stream (req_end_of_stream),
      .result        (conv_res)
   );

   assign req_ready = (count_ff <= CNT_W'(1));
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   // Lay out the new bytes at the tail; flags go on the final one
   always_comb begin
      wr_entry[0].data = conv_res.data0;
      wr_entry[1].data = conv_res.data1;
      wr_entry[2].data = conv_res.data2;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         wr_idx[i]        = tail_ff + PTR_W'(i);
         wr_entry[i].last = (conv_res.count == 2'(i + 1));
         wr_entry[i].done = (conv_res.count == 2'(i + 1)) && conv_res.done;
      end
   end

   // Advance pointers and occupancy
   always_comb begin
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff;
      count_in = count_ff - CNT_W'(pop);
      if (push) begin
         tail_in  = tail_ff + PTR_W'(conv_res.count);
         count_in = count_ff - CNT_W'(pop) + CNT_W'(conv_res.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Write the queue entries
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (push && (conv_res.count > 2'(i))) begin
            queue_ff[wr_idx[i]] <= wr_entry[i];
         end
      end
   end

   // Present the head entry
   assign rsp_out_byte    = queue_ff[head_ff].data;
   assign rsp_last_of_run = queue_ff[head_ff].last;
   assign rsp_stream_done = queue_ff[head_ff].done;

   `UFW_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH),
                      "output queue over capacity")
   `UFW_ASSERT_ALWAYS(a_ptr_match, count_ff[PTR_W-1:0] == PTR_W'(tail_ff - head_ff),
                      "queue pointers disagree with count")
   `UFW_ASSERT_SAME(a_eos_emits, push && req_end_of_stream, conv_res.count != 2'd0,
                    "end-of-stream request produced no byte")

endmodule

// ----- test/tb_utf8_fullwidth_to_halfwidth_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_fullwidth_to_halfwidth_core
   import utf8fw_pkg::*;
();

   localparam logic [7:0] LEAD_EF   = 8'hEF;
   localparam logic [7:0] SECOND_BD = 8'hBD;
   localparam logic [7:0] SECOND_BC = 8'hBC;
   localparam int RUN_ITEMS  = 90;
   localparam int DRAIN_WAIT = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       rsp_stream_done;

   // Predicted converter state
   logic [1:0] pend_count = 2'd0;
   logic [7:0] pend_second = 8'h00;
   logic       copy_raw_next = 1'b0;

   out_entry_type expected_bytes[$];
   out_entry_type next_expected;
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_left = 0;

   utf8_fullwidth_to_halfwidth_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_stream_done   (rsp_stream_done)
   );

   always #5 clock = ~clock;

   // Fold the third byte after EF BD; unchanged bytes come back as given
   function automatic logic [7:0] fold_after_bd(input logic [7:0] x);
      if (x >= 8'h41 && x <= 8'h5A) return x + 8'h20;
      if (x >= 8'h81 && x <= 8'h9A) return x - 8'h20;
      return x;
   endfunction

   // Fold the third byte after EF BC; unchanged bytes come back as given
   function automatic logic [7:0] fold_after_bc(input logic [7:0] x);
      if (x >= 8'h41 && x <= 8'h5A) return x + 8'h20;
      if (x >= 8'h90 && x <= 8'h99) return x - 8'h60;
      if (x >= 8'hA1 && x <= 8'hBB) return x - 8'h60;
      return x;
   endfunction

   // Advance the predicted state by one request and queue the bytes it yields
   function automatic void predict_conversion(input logic [7:0] b, input logic eos);
      logic [7:0] run[$];
      logic [7:0] folded;
      out_entry_type entry;
      if (copy_raw_next) begin
         copy_raw_next = 1'b0;
         pend_count = 2'd0;
         run.push_back(b);
      end else if (pend_count == 2'd1) begin
         if (b == SECOND_BD || b == SECOND_BC) begin
            pend_second = b;
            pend_count = 2'd2;
         end else begin
            run.push_back(LEAD_EF);
            run.push_back(b);
            pend_count = 2'd0;
            copy_raw_next = 1'b1;
         end
      end else if (pend_count == 2'd2) begin
         folded = (pend_second == SECOND_BD) ? fold_after_bd(b) : fold_after_bc(b);
         if (folded != b) begin
            run.push_back(folded);
         end else begin
            run.push_back(LEAD_EF);
            run.push_back(pend_second);
            run.push_back(b);
         end
         pend_count = 2'd0;
      end else begin
         pend_count = (b == LEAD_EF) ? 2'd1 : 2'd0;
         if (b != LEAD_EF) run.push_back(b);
      end
      // Flush held bytes raw at end of stream
      if (eos) begin
         if (pend_count >= 2'd1) run.push_back(LEAD_EF);
         if (pend_count == 2'd2) run.push_back(pend_second);
         pend_count = 2'd0;
         pend_second = 8'h00;
         copy_raw_next = 1'b0;
      end
      for (int i = 0; i < run.size(); i++) begin
         entry.data = run[i];
         entry.last = (i == run.size() - 1);
         entry.done = eos && (i == run.size() - 1);
         expected_bytes.push_back(entry);
      end
   endfunction

   // Offer one request, idling at random first, and hold it until accepted
   task automatic send_request(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_stream <= eos;
      predict_conversion(b, eos);
      do @(posedge clock); while (!req_ready);
   endtask

   // Send one mostly well-formed sequence with random content
   task automatic send_random_sequence(output int sent);
      logic [7:0] seq[$];
      int kind;
      int pick;
      logic [7:0] second;
      kind = $urandom_range(99);
      if (kind < 35) begin
         seq = '{LEAD_EF, SECOND_BD, 8'h00};
         seq[2] = $urandom_range(1) ? 8'($urandom_range(8'h9A, 8'h81))
                                    : 8'($urandom_range(8'h5A, 8'h41));
      end else if (kind < 60) begin
         seq = '{LEAD_EF, SECOND_BC, 8'h00};
         pick = $urandom_range(2);
         if (pick == 0) seq[2] = 8'($urandom_range(8'h99, 8'h90));
         else if (pick == 1) seq[2] = 8'($urandom_range(8'hBB, 8'hA1));
         else seq[2] = 8'($urandom_range(8'h5A, 8'h41));
      end else if (kind < 70) begin
         seq = '{LEAD_EF, $urandom_range(1) ? SECOND_BD : SECOND_BC,
                 8'($urandom_range(255))};
      end else if (kind < 80) begin
         second = 8'($urandom_range(255));
         if (second == SECOND_BD || second == SECOND_BC) second = 8'h00;
         seq = '{LEAD_EF, second, $urandom_range(1) ? LEAD_EF : 8'($urandom_range(255))};
      end else begin
         pick = $urandom_range(3, 1);
         for (int i = 0; i < pick; i++) seq.push_back(8'($urandom_range(255)));
      end
      foreach (seq[i]) send_request(seq[i], $urandom_range(99) < 3);
      sent = seq.size();
   endtask

   // Check every accepted response against the predicted bytes
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected response byte: actual %h", rsp_out_byte);
            fail_count++;
         end else begin
            next_expected = expected_bytes.pop_front();
            if (rsp_out_byte !== next_expected.data) begin
               $error("out_byte: expected %h, actual %h", next_expected.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_of_run !== next_expected.last) begin
               $error("last_of_run: expected %b, actual %b",
                      next_expected.last, rsp_last_of_run);
               fail_count++;
            end
            if (rsp_stream_done !== next_expected.done) begin
               $error("stream_done: expected %b, actual %b",
                      next_expected.done, rsp_stream_done);
               fail_count++;
            end
         end
      end
   end

   // Stall the response side at random, or for a long counted stretch
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic test_plain_bytes();
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
   endtask

   task automatic test_fullwidth_lower();
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BD, 1'b0);
      send_request(8'h81, 1'b0);
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BD, 1'b0);
      send_request(8'h5A, 1'b0);
   endtask

   task automatic test_fullwidth_upper();
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BC, 1'b0);
      send_request(8'h90, 1'b0);
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BC, 1'b0);
      send_request(8'hBB, 1'b0);
   endtask

   // Lead with another second byte: the following lead byte is copied raw
   task automatic test_other_second();
      send_request(LEAD_EF, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(LEAD_EF, 1'b0);
   endtask

   // Third byte outside the table: all three bytes pass through
   task automatic test_unchanged_third();
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BD, 1'b0);
      send_request(8'h20, 1'b0);
   endtask

   // Flush held bytes at end of stream and drop a pending raw copy
   task automatic test_end_of_stream();
      send_request(LEAD_EF, 1'b0);
      send_request(SECOND_BC, 1'b1);
      send_request(LEAD_EF, 1'b0);
      send_request(8'h41, 1'b1);
      send_request(LEAD_EF, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int sent;
      int total;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      total = 0;
      while (total < RUN_ITEMS) begin
         send_random_sequence(sent);
         total += sent;
      end
   endtask

   // Hold off the receiver long enough for the block to fill and stall requests
   task automatic test_output_backpressure();
      int sent;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_left = 300;
      for (int i = 0; i < 12; i++) send_random_sequence(sent);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_bytes();
      test_fullwidth_lower();
      test_fullwidth_upper();
      test_other_second();
      test_unchanged_third();
      test_end_of_stream();
      test_random_traffic(0, 0);
      test_random_traffic(57, 0);
      test_random_traffic(0, 57);
      test_random_traffic(22, 22);
      test_output_backpressure();
      req_valid <= 1'b0;
      // Drain outstanding responses, then watch for strays
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_fullwidth_to_halfwidth_core: match");
      end else begin
         $display("utf8_fullwidth_to_halfwidth_core: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("utf8_fullwidth_to_halfwidth_core: mismatch");
      $finish;
   end

endmodule
